/* rtl/sdt_pkg.sv */
// Shared types and constants for the signed day/second/nanosecond time add/sub unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdt_pkg;

    localparam int NS_WIDTH  = 30;
    localparam int SEC_WIDTH = 17;

    localparam logic [NS_WIDTH-1:0]  NS_PER_SEC  = 30'd1000000000;
    localparam logic [SEC_WIDTH-1:0] SEC_PER_DAY = 17'd86400;
    localparam logic [SEC_WIDTH-1:0] SEC_MAX     = 17'd86399;

    localparam logic OP_INTERVAL = 1'b0;
    localparam logic OP_ADD      = 1'b1;

    typedef logic [NS_WIDTH-1:0]  ns_t;
    typedef logic [SEC_WIDTH-1:0] sec_t;

    // per-item control that rides along the pipe
    typedef struct packed {
        logic do_add;
        logic sign;
    } ctrl_t;

endpackage

`default_nettype wire

/* rtl/sdt_op_if.sv */
// Operand channel (valid/ready) of the time add/sub unit.
// Depends on sdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sdt_op_if #(
    parameter int DAY_WIDTH = 16
);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic                 a_sign;
    logic [DAY_WIDTH-1:0] a_day;
    sdt_pkg::sec_t        a_second;
    sdt_pkg::ns_t         a_ns;
    logic                 b_sign;
    logic [DAY_WIDTH-1:0] b_day;
    sdt_pkg::sec_t        b_second;
    sdt_pkg::ns_t         b_ns;

    modport source (
        output valid, operation, a_sign, a_day, a_second, a_ns,
               b_sign, b_day, b_second, b_ns,
        input  ready
    );
    modport sink (
        input  valid, operation, a_sign, a_day, a_second, a_ns,
               b_sign, b_day, b_second, b_ns,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/sdt_res_if.sv */
// Result channel (valid/ready) of the time add/sub unit.
// Depends on sdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sdt_res_if #(
    parameter int DAY_WIDTH = 16
);
    logic                 valid;
    logic                 ready;
    logic                 result_sign;
    logic [DAY_WIDTH-1:0] result_day;
    sdt_pkg::sec_t        result_second;
    sdt_pkg::ns_t         result_ns;
    logic                 day_overflow;

    modport source (
        output valid, result_sign, result_day, result_second, result_ns, day_overflow,
        input  ready
    );
    modport sink (
        input  valid, result_sign, result_day, result_second, result_ns, day_overflow,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/signed_day_second_ns_time_add_sub_unit.sv */
// Top level of the signed day/second/nanosecond time add/sub unit.
// Depends on sdt_pkg, sdt_op_if, sdt_res_if, sdt_cmp, sdt_ns, sdt_sec_day.
`timescale 1ns / 1ps
`default_nettype none

// Adds or takes the interval of two sign-magnitude time values (sign, day,
// second of day, nanosecond). The block is a five-stage pipeline: compare and
// swap, nanosecond add/subtract, nanosecond correction, second add/subtract,
// second correction with the final day carry or borrow. It accepts one item
// per cycle when the result side is ready, and each result is registered at
// every stage on its way out. Each stage holds its item under backpressure and
// empty stages take new items, so input ready follows result ready through a
// short combinational chain. The day count is DAY_WIDTH bits and wraps, with
// day_overflow set; DAY_WIDTH must match the interfaces' parameter.

module signed_day_second_ns_time_add_sub_unit #(
    parameter int DAY_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sdt_op_if.sink    operands,
    sdt_res_if.source results
);

    logic                 c_valid, c_ready;
    sdt_pkg::ctrl_t       c_ctrl;
    logic [DAY_WIDTH-1:0] c_hi_day, c_lo_day;
    sdt_pkg::sec_t        c_hi_sec, c_lo_sec;
    sdt_pkg::ns_t         c_hi_ns, c_lo_ns;

    logic                 n_valid, n_ready;
    sdt_pkg::ctrl_t       n_ctrl;
    logic [DAY_WIDTH-1:0] n_hi_day, n_lo_day;
    sdt_pkg::sec_t        n_sec_hi, n_sec_lo;
    logic                 n_carry;
    sdt_pkg::ns_t         n_ns;

    sdt_cmp #(
        .DAY_WIDTH (DAY_WIDTH)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .operation (operands.operation),
        .a_sign    (operands.a_sign),
        .a_day     (operands.a_day),
        .a_second  (operands.a_second),
        .a_ns      (operands.a_ns),
        .b_sign    (operands.b_sign),
        .b_day     (operands.b_day),
        .b_second  (operands.b_second),
        .b_ns      (operands.b_ns),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_ctrl  (c_ctrl),
        .hi_day    (c_hi_day),
        .hi_sec    (c_hi_sec),
        .hi_ns     (c_hi_ns),
        .lo_day    (c_lo_day),
        .lo_sec    (c_lo_sec),
        .lo_ns     (c_lo_ns)
    );

    sdt_ns #(
        .DAY_WIDTH (DAY_WIDTH)
    ) u_ns (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (c_valid),
        .in_ready   (c_ready),
        .in_ctrl    (c_ctrl),
        .hi_day     (c_hi_day),
        .hi_sec     (c_hi_sec),
        .hi_ns      (c_hi_ns),
        .lo_day     (c_lo_day),
        .lo_sec     (c_lo_sec),
        .lo_ns      (c_lo_ns),
        .out_valid  (n_valid),
        .out_ready  (n_ready),
        .out_ctrl   (n_ctrl),
        .out_hi_day (n_hi_day),
        .out_lo_day (n_lo_day),
        .sec_hi     (n_sec_hi),
        .sec_lo     (n_sec_lo),
        .ns_carry   (n_carry),
        .ns_res     (n_ns)
    );

    sdt_sec_day #(
        .DAY_WIDTH (DAY_WIDTH)
    ) u_sec_day (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (n_valid),
        .in_ready      (n_ready),
        .in_ctrl       (n_ctrl),
        .hi_day        (n_hi_day),
        .lo_day        (n_lo_day),
        .sec_hi        (n_sec_hi),
        .sec_lo        (n_sec_lo),
        .ns_carry      (n_carry),
        .ns_res        (n_ns),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .result_sign   (results.result_sign),
        .result_day    (results.result_day),
        .result_second (results.result_second),
        .result_ns     (results.result_ns),
        .day_overflow  (results.day_overflow)
    );

endmodule

`default_nettype wire

/* rtl/sdt_cmp.sv */
// Stage 1: magnitude compare, operand swap (larger first) and result sign.
// Depends on sdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdt_cmp #(
    parameter int DAY_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic                 a_sign,
    input  wire logic [DAY_WIDTH-1:0] a_day,
    input  wire sdt_pkg::sec_t        a_second,
    input  wire sdt_pkg::ns_t         a_ns,
    input  wire logic                 b_sign,
    input  wire logic [DAY_WIDTH-1:0] b_day,
    input  wire sdt_pkg::sec_t        b_second,
    input  wire sdt_pkg::ns_t         b_ns,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sdt_pkg::ctrl_t            out_ctrl,
    output logic [DAY_WIDTH-1:0]      hi_day,
    output sdt_pkg::sec_t             hi_sec,
    output sdt_pkg::ns_t              hi_ns,
    output logic [DAY_WIDTH-1:0]      lo_day,
    output sdt_pkg::sec_t             lo_sec,
    output sdt_pkg::ns_t              lo_ns
);

    logic                 valid_reg;
    sdt_pkg::ctrl_t       ctrl_reg, ctrl_next;
    logic [DAY_WIDTH-1:0] hi_day_reg, hi_day_next, lo_day_reg, lo_day_next;
    sdt_pkg::sec_t        hi_sec_reg, hi_sec_next, lo_sec_reg, lo_sec_next;
    sdt_pkg::ns_t         hi_ns_reg, hi_ns_next, lo_ns_reg, lo_ns_next;
    logic                 b_big;
    logic                 big_sign;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // equal magnitudes count a as the larger
        b_big = (b_day > a_day)
             || ((b_day == a_day) && (b_second > a_second))
             || ((b_day == a_day) && (b_second == a_second) && (b_ns > a_ns));
        big_sign = b_big ? b_sign : a_sign;

        if (operation == sdt_pkg::OP_INTERVAL)
        begin
            ctrl_next.do_add = (a_sign != b_sign);
            ctrl_next.sign   = (a_sign != b_sign) ? big_sign : a_sign;
        end
        else
        begin
            ctrl_next.do_add = (a_sign == b_sign);
            ctrl_next.sign   = (a_sign == b_sign) ? a_sign : big_sign;
        end

        hi_day_next = b_big ? b_day    : a_day;
        hi_sec_next = b_big ? b_second : a_second;
        hi_ns_next  = b_big ? b_ns     : a_ns;
        lo_day_next = b_big ? a_day    : b_day;
        lo_sec_next = b_big ? a_second : b_second;
        lo_ns_next  = b_big ? a_ns     : b_ns;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ctrl_reg   <= ctrl_next;
            hi_day_reg <= hi_day_next;
            hi_sec_reg <= hi_sec_next;
            hi_ns_reg  <= hi_ns_next;
            lo_day_reg <= lo_day_next;
            lo_sec_reg <= lo_sec_next;
            lo_ns_reg  <= lo_ns_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign hi_day    = hi_day_reg;
    assign hi_sec    = hi_sec_reg;
    assign hi_ns     = hi_ns_reg;
    assign lo_day    = lo_day_reg;
    assign lo_sec    = lo_sec_reg;
    assign lo_ns     = lo_ns_reg;

endmodule

`default_nettype wire

/* rtl/sdt_ns.sv */
// Stages 2 and 3: nanosecond add/subtract, then carry or borrow correction
// and the matching adjustment of the larger value's second. Depends on sdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdt_ns #(
    parameter int DAY_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sdt_pkg::ctrl_t       in_ctrl,
    input  wire logic [DAY_WIDTH-1:0] hi_day,
    input  wire sdt_pkg::sec_t        hi_sec,
    input  wire sdt_pkg::ns_t         hi_ns,
    input  wire logic [DAY_WIDTH-1:0] lo_day,
    input  wire sdt_pkg::sec_t        lo_sec,
    input  wire sdt_pkg::ns_t         lo_ns,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sdt_pkg::ctrl_t            out_ctrl,
    output logic [DAY_WIDTH-1:0]      out_hi_day,
    output logic [DAY_WIDTH-1:0]      out_lo_day,
    output sdt_pkg::sec_t             sec_hi,
    output sdt_pkg::sec_t             sec_lo,
    output logic                      ns_carry,
    output sdt_pkg::ns_t              ns_res
);

    localparam int NSW = sdt_pkg::NS_WIDTH;

    // stage 2
    logic                 s2_valid_reg;
    logic                 s2_ready;
    sdt_pkg::ctrl_t       s2_ctrl_reg;
    logic [DAY_WIDTH-1:0] s2_hi_day_reg, s2_lo_day_reg;
    sdt_pkg::sec_t        s2_hi_sec_reg, s2_lo_sec_reg;
    logic [NSW:0]         s2_ns_add_reg, s2_ns_add_next;
    logic [NSW:0]         s2_ns_sub_reg, s2_ns_sub_next;

    // stage 3
    logic                 s3_valid_reg;
    sdt_pkg::ctrl_t       s3_ctrl_reg;
    logic [DAY_WIDTH-1:0] s3_hi_day_reg, s3_lo_day_reg;
    sdt_pkg::sec_t        s3_sec_hi_reg, s3_sec_hi_next, s3_sec_lo_reg;
    logic                 s3_carry_reg, s3_carry_next;
    sdt_pkg::ns_t         s3_ns_reg, s3_ns_next;
    logic                 add_carry;
    logic                 sub_borrow;

    assign s2_ready = !s3_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || s2_ready;

    always_comb
    begin
        s2_ns_add_next = {1'b0, hi_ns} + {1'b0, lo_ns};
        // top bit is the borrow
        s2_ns_sub_next = {1'b0, hi_ns} - {1'b0, lo_ns};
    end

    always_comb
    begin
        add_carry  = (s2_ns_add_reg >= {1'b0, sdt_pkg::NS_PER_SEC});
        sub_borrow = s2_ns_sub_reg[NSW];
        if (s2_ctrl_reg.do_add)
        begin
            s3_ns_next     = add_carry ? s2_ns_add_reg[NSW-1:0] - sdt_pkg::NS_PER_SEC
                                       : s2_ns_add_reg[NSW-1:0];
            s3_sec_hi_next = s2_hi_sec_reg;
            s3_carry_next  = add_carry;
        end
        else
        begin
            s3_ns_next = sub_borrow ? s2_ns_sub_reg[NSW-1:0] + sdt_pkg::NS_PER_SEC
                                    : s2_ns_sub_reg[NSW-1:0];
            // borrowing from second zero wraps it and takes a day
            if (sub_borrow && (s2_hi_sec_reg == '0))
                s3_sec_hi_next = sdt_pkg::SEC_MAX;
            else if (sub_borrow)
                s3_sec_hi_next = s2_hi_sec_reg - sdt_pkg::sec_t'(1);
            else
                s3_sec_hi_next = s2_hi_sec_reg;
            s3_carry_next = sub_borrow && (s2_hi_sec_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s2_valid_reg <= in_valid;
            if (s2_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s2_ctrl_reg   <= in_ctrl;
            s2_hi_day_reg <= hi_day;
            s2_lo_day_reg <= lo_day;
            s2_hi_sec_reg <= hi_sec;
            s2_lo_sec_reg <= lo_sec;
            s2_ns_add_reg <= s2_ns_add_next;
            s2_ns_sub_reg <= s2_ns_sub_next;
        end
        if (s2_valid_reg && s2_ready)
        begin
            s3_ctrl_reg   <= s2_ctrl_reg;
            s3_hi_day_reg <= s2_hi_day_reg;
            s3_lo_day_reg <= s2_lo_day_reg;
            s3_sec_hi_reg <= s3_sec_hi_next;
            s3_sec_lo_reg <= s2_lo_sec_reg;
            s3_carry_reg  <= s3_carry_next;
            s3_ns_reg     <= s3_ns_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_ctrl   = s3_ctrl_reg;
    assign out_hi_day = s3_hi_day_reg;
    assign out_lo_day = s3_lo_day_reg;
    assign sec_hi     = s3_sec_hi_reg;
    assign sec_lo     = s3_sec_lo_reg;
    assign ns_carry   = s3_carry_reg;
    assign ns_res     = s3_ns_reg;

endmodule

`default_nettype wire

/* rtl/sdt_sec_day.sv */
// Stages 4 and 5: second add/subtract and partial day result, then second
// correction, final day carry or borrow and overflow flag. Depends on sdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdt_sec_day #(
    parameter int DAY_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sdt_pkg::ctrl_t       in_ctrl,
    input  wire logic [DAY_WIDTH-1:0] hi_day,
    input  wire logic [DAY_WIDTH-1:0] lo_day,
    input  wire sdt_pkg::sec_t        sec_hi,
    input  wire sdt_pkg::sec_t        sec_lo,
    input  wire logic                 ns_carry,
    input  wire sdt_pkg::ns_t         ns_res,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      result_sign,
    output logic [DAY_WIDTH-1:0]      result_day,
    output sdt_pkg::sec_t             result_second,
    output sdt_pkg::ns_t              result_ns,
    output logic                      day_overflow
);

    localparam int SW  = sdt_pkg::SEC_WIDTH;
    localparam int DXW = DAY_WIDTH + 2;

    // stage 4
    logic           s4_valid_reg;
    logic           s4_ready;
    sdt_pkg::ctrl_t s4_ctrl_reg;
    logic [SW:0]    s4_sec_add_reg, s4_sec_add_next;
    logic [SW:0]    s4_sec_sub_reg, s4_sec_sub_next;
    logic [DXW-1:0] s4_day_reg, s4_day_next;
    sdt_pkg::ns_t   s4_ns_reg;

    // stage 5
    logic           s5_valid_reg;
    logic           s5_sign_reg;
    logic [DAY_WIDTH-1:0] s5_day_reg, s5_day_next;
    sdt_pkg::sec_t  s5_sec_reg, s5_sec_next;
    sdt_pkg::ns_t   s5_ns_reg;
    logic           s5_ovf_reg, s5_ovf_next;
    logic           sec_carry;
    logic           sec_borrow;
    logic [DXW-1:0] day_full;

    assign s4_ready = !s5_valid_reg || out_ready;
    assign in_ready = !s4_valid_reg || s4_ready;

    always_comb
    begin
        s4_sec_add_next = {1'b0, sec_hi} + {1'b0, sec_lo} + {{SW{1'b0}}, ns_carry};
        s4_sec_sub_next = {1'b0, sec_hi} - {1'b0, sec_lo};
        // sum or signed difference in the wide form; a negative difference means the day wrapped
        if (in_ctrl.do_add)
            s4_day_next = {2'b00, hi_day} + {2'b00, lo_day};
        else
            s4_day_next = {2'b00, hi_day} - {2'b00, lo_day} - {{(DXW-1){1'b0}}, ns_carry};
    end

    always_comb
    begin
        sec_carry  = (s4_sec_add_reg >= {1'b0, sdt_pkg::SEC_PER_DAY});
        sec_borrow = s4_sec_sub_reg[SW];
        if (s4_ctrl_reg.do_add)
        begin
            s5_sec_next = sec_carry ? s4_sec_add_reg[SW-1:0] - sdt_pkg::SEC_PER_DAY
                                    : s4_sec_add_reg[SW-1:0];
            day_full    = s4_day_reg + {{(DXW-1){1'b0}}, sec_carry};
            s5_ovf_next = day_full[DAY_WIDTH];
        end
        else
        begin
            s5_sec_next = sec_borrow ? s4_sec_sub_reg[SW-1:0] + sdt_pkg::SEC_PER_DAY
                                     : s4_sec_sub_reg[SW-1:0];
            day_full    = s4_day_reg - {{(DXW-1){1'b0}}, sec_borrow};
            s5_ovf_next = day_full[DXW-1];
        end
        s5_day_next = day_full[DAY_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s4_valid_reg <= in_valid;
            if (s4_ready)
                s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s4_ctrl_reg    <= in_ctrl;
            s4_sec_add_reg <= s4_sec_add_next;
            s4_sec_sub_reg <= s4_sec_sub_next;
            s4_day_reg     <= s4_day_next;
            s4_ns_reg      <= ns_res;
        end
        if (s4_valid_reg && s4_ready)
        begin
            s5_sign_reg <= s4_ctrl_reg.sign;
            s5_day_reg  <= s5_day_next;
            s5_sec_reg  <= s5_sec_next;
            s5_ns_reg   <= s4_ns_reg;
            s5_ovf_reg  <= s5_ovf_next;
        end
    end

    assign out_valid     = s5_valid_reg;
    assign result_sign   = s5_sign_reg;
    assign result_day    = s5_day_reg;
    assign result_second = s5_sec_reg;
    assign result_ns     = s5_ns_reg;
    assign day_overflow  = s5_ovf_reg;

endmodule

`default_nettype wire

/* bench/sdt_time_checker.sv */
// Checker for the signed day/second/nanosecond time add/sub unit: watches both channels,
// predicts each result and compares it with the unit's output.
// Depends on sdt_pkg, sdt_op_if, sdt_res_if.
`timescale 1ns / 1ps

module sdt_time_checker #(
    parameter int DAY_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    sdt_op_if    opch,
    sdt_res_if   resch,
    output int   errors,
    output int   pending,
    output int   checked
);
    import sdt_pkg::*;

    typedef logic [DAY_WIDTH-1:0] day_t;

    typedef struct packed {
        logic sign;
        day_t day;
        sec_t sec;
        ns_t  ns;
        logic ovf;
    } time_result_t;

    localparam logic [63:0] DAY_LIMIT = (64'd1 << DAY_WIDTH) - 64'd1;

    time_result_t sum_q[$];
    int           fail_count;
    int           result_count;

    function automatic time_result_t predict_time(
        input logic op,
        input logic sa, input day_t da, input sec_t sca, input ns_t na,
        input logic sb, input day_t db, input sec_t scb, input ns_t nb
    );
        time_result_t r;
        logic         b_larger;
        logic         sum_path;
        logic [31:0]  ns_w;
        logic [31:0]  sec_w;
        logic [31:0]  hs;
        logic [63:0]  day_w;
        logic [63:0]  need;
        logic [63:0]  borrow;
        day_t         hi_day, lo_day;
        sec_t         hi_sec, lo_sec;
        ns_t          hi_ns, lo_ns;

        if (da != db)
            b_larger = db > da;
        else if (sca != scb)
            b_larger = scb > sca;
        else
            b_larger = nb > na;

        sum_path = (op == OP_INTERVAL) ? (sa != sb) : (sa == sb);

        if (sum_path)
        begin
            ns_w  = 32'(na) + 32'(nb);
            sec_w = 32'(sca) + 32'(scb);
            day_w = 64'(da) + 64'(db);
            // one correction per unit, even for out-of-range inputs
            if (ns_w >= 32'(NS_PER_SEC))
            begin
                ns_w  = ns_w - 32'(NS_PER_SEC);
                sec_w = sec_w + 32'd1;
            end
            if (sec_w >= 32'(SEC_PER_DAY))
            begin
                sec_w = sec_w - 32'(SEC_PER_DAY);
                day_w = day_w + 64'd1;
            end
            r.ovf  = day_w > DAY_LIMIT;
            r.sign = (op == OP_INTERVAL) ? (b_larger ? sb : sa) : sa;
        end
        else
        begin
            hi_day = b_larger ? db : da;
            hi_sec = b_larger ? scb : sca;
            hi_ns  = b_larger ? nb : na;
            lo_day = b_larger ? da : db;
            lo_sec = b_larger ? sca : scb;
            lo_ns  = b_larger ? na : nb;
            hs     = 32'(hi_sec);
            borrow = 64'd0;
            if (hi_ns >= lo_ns)
                ns_w = 32'(hi_ns) - 32'(lo_ns);
            else
            begin
                ns_w = 32'(NS_PER_SEC) - (32'(lo_ns) - 32'(hi_ns));
                // borrow from second zero goes straight through to the day
                if (hs == 32'd0)
                begin
                    hs     = 32'(SEC_MAX);
                    borrow = borrow + 64'd1;
                end
                else
                    hs = hs - 32'd1;
            end
            if (hs >= 32'(lo_sec))
                sec_w = hs - 32'(lo_sec);
            else
            begin
                sec_w  = 32'(SEC_PER_DAY) - (32'(lo_sec) - hs);
                borrow = borrow + 64'd1;
            end
            need   = 64'(lo_day) + borrow;
            r.ovf  = 64'(hi_day) < need;
            day_w  = 64'(hi_day) - need;
            r.sign = (op == OP_INTERVAL) ? sa : (b_larger ? sb : sa);
        end

        r.day = day_w[DAY_WIDTH-1:0];
        r.sec = sec_w[SEC_WIDTH-1:0];
        r.ns  = ns_w[NS_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        time_result_t want;
        time_result_t got;
        if (!rst_n)
        begin
            sum_q.delete();
            fail_count   = 0;
            result_count = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (opch.valid && opch.ready)
                sum_q.push_back(predict_time(opch.operation,
                    opch.a_sign, opch.a_day, opch.a_second, opch.a_ns,
                    opch.b_sign, opch.b_day, opch.b_second, opch.b_ns));

            if (resch.valid && resch.ready)
            begin
                got.sign = resch.result_sign;
                got.day  = resch.result_day;
                got.sec  = resch.result_second;
                got.ns   = resch.result_ns;
                got.ovf  = resch.day_overflow;
                if (sum_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result item with nothing outstanding", $time);
                end
                else
                begin
                    want = sum_q.pop_front();
                    if (got.sign != want.sign || got.day != want.day ||
                        got.sec != want.sec || got.ns != want.ns || got.ovf != want.ovf)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: result %0d mismatch", $time, result_count);
                            $display("  exp sign=%0b day=%0d sec=%0d ns=%0d ovf=%0b",
                                     want.sign, want.day, want.sec, want.ns, want.ovf);
                            $display("  got sign=%0b day=%0d sec=%0d ns=%0d ovf=%0b",
                                     got.sign, got.day, got.sec, got.ns, got.ovf);
                        end
                    end
                end
                result_count++;
            end

            errors  <= fail_count;
            pending <= sum_q.size();
            checked <= result_count;
        end
    end

endmodule

/* bench/tb.sv */
// Testbench top for the signed day/second/nanosecond time add/sub unit: drives
// directed and random operand items with random idling on both channels.
// Depends on sdt_pkg, sdt_op_if, sdt_res_if, sdt_time_checker and the unit.
`timescale 1ns / 1ps

module tb;
    import sdt_pkg::*;

    localparam int DAY_W        = 16;
    localparam int RANDOM_ITEMS = 1200;

    typedef logic [DAY_W-1:0] day_t;

    typedef struct packed {
        logic sign;
        day_t day;
        sec_t sec;
        ns_t  ns;
    } stamp_t;

    localparam day_t DAY_MAX = '1;
    localparam sec_t SEC_ALL = '1;
    localparam ns_t  NS_ALL  = '1;
    localparam ns_t  NS_MAX  = NS_PER_SEC - 30'd1;

    logic clk = 1'b0;
    logic rst_n;
    logic idle_on;
    int   items_sent;
    int   chk_errors;
    int   chk_pending;
    int   chk_results;

    sdt_op_if  #(.DAY_WIDTH(DAY_W)) opif ();
    sdt_res_if #(.DAY_WIDTH(DAY_W)) resif ();

    signed_day_second_ns_time_add_sub_unit #(.DAY_WIDTH(DAY_W)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (opif),
        .results  (resif)
    );

    sdt_time_checker #(.DAY_WIDTH(DAY_W)) chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .opch    (opif),
        .resch   (resif),
        .errors  (chk_errors),
        .pending (chk_pending),
        .checked (chk_results)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic stamp_t stamp(logic s, day_t d, sec_t sc, ns_t n);
        return '{s, d, sc, n};
    endfunction

    function automatic day_t rand_day();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return day_t'($urandom_range(0, 3));
        if (pick < 4)
            return DAY_MAX - day_t'($urandom_range(0, 3));
        return day_t'($urandom);
    endfunction

    function automatic sec_t rand_sec();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 1)
            return sec_t'($urandom_range(86400, 131071));
        if (pick < 3)
            return $urandom_range(0, 1) ? sec_t'($urandom_range(0, 1))
                                        : SEC_MAX - sec_t'($urandom_range(0, 1));
        return sec_t'($urandom_range(0, 86399));
    endfunction

    function automatic ns_t rand_ns();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 1)
            return ns_t'($urandom_range(1000000000, 1073741823));
        if (pick < 3)
            return $urandom_range(0, 1) ? ns_t'($urandom_range(0, 1))
                                        : NS_MAX - ns_t'($urandom_range(0, 1));
        return ns_t'($urandom_range(0, 999999999));
    endfunction

    // present one operand item, optionally after an idle burst, and wait for it to be taken
    task automatic push_op(input logic op, input stamp_t a, input stamp_t b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            opif.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        opif.valid     <= 1'b1;
        opif.operation <= op;
        opif.a_sign    <= a.sign;
        opif.a_day     <= a.day;
        opif.a_second  <= a.sec;
        opif.a_ns      <= a.ns;
        opif.b_sign    <= b.sign;
        opif.b_day     <= b.day;
        opif.b_second  <= b.sec;
        opif.b_ns      <= b.ns;
        @(posedge clk);
        while (!opif.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending and wait until every outstanding result has come back
    task automatic drain();
        opif.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // result side: random stall bursts while idle_on is set
    initial
    begin
        resif.ready <= 1'b0;
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                resif.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            resif.ready <= 1'b1;
        end
    end

    initial
    begin
        stamp_t a;
        stamp_t b;
        logic   op;
        int     directed;

        items_sent     = 0;
        idle_on        = 1'b1;
        rst_n          <= 1'b0;
        opif.valid     <= 1'b0;
        opif.operation <= OP_INTERVAL;
        opif.a_sign    <= 1'b0;
        opif.a_day     <= '0;
        opif.a_second  <= '0;
        opif.a_ns      <= '0;
        opif.b_sign    <= 1'b0;
        opif.b_day     <= '0;
        opif.b_second  <= '0;
        opif.b_ns      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zeros, full-scale carries, equal magnitudes, borrows, out-of-range fields
        push_op(OP_INTERVAL, stamp(0, 0, 0, 0), stamp(0, 0, 0, 0));
        push_op(OP_ADD, stamp(0, DAY_MAX, SEC_MAX, NS_MAX), stamp(0, DAY_MAX, SEC_MAX, NS_MAX));
        push_op(OP_ADD, stamp(1, 7, 300, 42), stamp(0, 7, 300, 42));
        push_op(OP_INTERVAL, stamp(1, DAY_MAX, SEC_MAX, NS_MAX),
                stamp(0, DAY_MAX, SEC_MAX, NS_MAX));
        // ns borrow hits second zero of the larger value
        push_op(OP_INTERVAL, stamp(1, 5, 100, 5), stamp(1, 7, 0, 3));
        push_op(OP_ADD, stamp(0, 2, 50, 0), stamp(1, 9, 10, 1));
        push_op(OP_ADD, stamp(0, 0, 0, NS_MAX), stamp(0, 0, 0, 1));
        push_op(OP_ADD, stamp(1, 3, SEC_MAX, 0), stamp(1, 4, 1, 0));
        push_op(OP_ADD, stamp(0, 0, SEC_MAX, NS_MAX), stamp(0, 0, 0, 1));
        push_op(OP_ADD, stamp(0, DAY_MAX, SEC_ALL, NS_ALL), stamp(0, DAY_MAX, SEC_ALL, NS_ALL));
        push_op(OP_INTERVAL, stamp(0, 3, SEC_ALL, NS_ALL), stamp(0, 3, 0, NS_PER_SEC + 30'd5));
        push_op(OP_INTERVAL, stamp(1, 10, 5, 0), stamp(1, 3, 100, 0));
        push_op(OP_ADD, stamp(1, 1, 1, 1), stamp(1, 2, 2, 2));
        push_op(OP_INTERVAL, stamp(0, 1, 0, 0), stamp(1, 100, 0, 0));
        push_op(OP_INTERVAL, stamp(0, DAY_MAX, 0, 0), stamp(0, 0, SEC_MAX, NS_MAX));
        push_op(OP_ADD, stamp(1, 0, SEC_PER_DAY, NS_PER_SEC), stamp(1, 0, SEC_PER_DAY, NS_PER_SEC));
        push_op(OP_INTERVAL, stamp(0, 0, 5, 0), stamp(0, 0, 1, NS_ALL));
        push_op(OP_ADD, stamp(0, 0, 0, 0), stamp(1, 0, 0, 1));
        push_op(OP_INTERVAL, stamp(0, 9, 9, 9), stamp(1, 9, 9, 9));
        push_op(OP_ADD, stamp(0, 2, SEC_ALL, 0), stamp(1, 2, SEC_PER_DAY, NS_ALL));
        directed = items_sent;
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // idle, then a clean stretch, idle again, and a clean tail
            idle_on = (i < 400) || (i >= 600 && i < 1000);
            if (i == 700)
                drain();
            op = $urandom_range(0, 1) ? OP_ADD : OP_INTERVAL;
            a  = stamp($urandom_range(0, 1), rand_day(), rand_sec(), rand_ns());
            b  = stamp($urandom_range(0, 1), rand_day(), rand_sec(), rand_ns());
            // close magnitudes so the compare goes down to seconds and ns
            if ($urandom_range(0, 3) == 0)
            begin
                b.day = a.day;
                if ($urandom_range(0, 1))
                begin
                    b.sec = a.sec;
                    if ($urandom_range(0, 2) == 0)
                        b.ns = a.ns + ns_t'($urandom_range(0, 2)) - ns_t'(1);
                end
            end
            push_op(op, a, b);
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d items (%0d directed), checked %0d results.",
                 items_sent, directed, chk_results);
        $display("Both operations and sign mixes, carries, borrows, wraps, out-of-range fields.");
        if (chk_errors == 0 && chk_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
